/* src/mld_pkg.sv */
// Shared types and constants for the MLD listener report parser.
`timescale 1ns / 1ps

package mld_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PORT_W      = 4;
    localparam int unsigned ADDR_W      = 128;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned AUX_W       = 10;
    localparam int unsigned OUT_TDATA_W = 264;
    localparam int unsigned OUT_TUSER_W = 2;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT_TAG_BYTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_TAG_NIBBLE = 2'd1;

    localparam logic [BYTE_W-1:0] TAG_BYTE_RESET   = 8'h7d;
    localparam logic [PORT_W-1:0] TAG_NIBBLE_RESET = 4'h5;

    localparam logic [BYTE_W-1:0] TYPE_V1_REPORT = 8'd131;
    localparam logic [BYTE_W-1:0] TYPE_V1_DONE   = 8'd132;
    localparam logic [BYTE_W-1:0] TYPE_V2_REPORT = 8'd143;

    localparam logic [BYTE_W-1:0] REC_IS_INCLUDE = 8'd1;
    localparam logic [BYTE_W-1:0] REC_IS_EXCLUDE = 8'd2;
    localparam logic [BYTE_W-1:0] REC_TO_INCLUDE = 8'd3;
    localparam logic [BYTE_W-1:0] REC_TO_EXCLUDE = 8'd4;

    localparam logic [POS_W-1:0] POS_CSUM_LOW  = 4'd3;
    localparam logic [POS_W-1:0] POS_HDR_LAST  = 4'd7;
    localparam logic [POS_W-1:0] POS_REC_TYPE  = 4'd0;
    localparam logic [POS_W-1:0] POS_REC_AUX   = 4'd1;
    localparam logic [POS_W-1:0] POS_REC_NSRCH = 4'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LAST = 4'd15;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_V1_JOIN  = 2'd1,
        KIND_V1_LEAVE = 2'd2,
        KIND_V2       = 2'd3
    } kind_t;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_RECHDR = 6'b000100,
        PH_GROUP  = 6'b001000,
        PH_SOURCE = 6'b010000,
        PH_AUX    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic              action;
        logic              from_version_one;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] group;
        logic [ADDR_W-1:0] source;
    } event_t;

endpackage

/* src/mld_report_parser.sv */
// Top level of the MLD listener report parser: stream ports, config and registers.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    tdata: data_byte; tuser: start_of_message
//  m_*      out  m_tvalid / m_tready    tdata: port, group, source; tuser: action, v1 flag
//  cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One byte per cycle while m_* is not stalled; an accepted byte is held in the input register
//  and its event, if any, is registered for m_* when the parser steps on that byte.
//  The parser step per byte is a single pass through the state update logic.
//  A stalled result holds the parser; the input register still takes one byte if it is empty.
//  rst_n clears the parser to idle and the tag registers to their defaults.
`timescale 1ns / 1ps

module mld_report_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mld_pkg::BYTE_W-1:0]          s_tdata,  // [7:0] data_byte
    input  logic                                s_tuser,  // [0] start_of_message
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mld_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [3:0] port, [67:4] group_high,
                                                          // [131:68] group_low,
                                                          // [195:132] source_high,
                                                          // [259:196] source_low, rest 0
    output logic [mld_pkg::OUT_TUSER_W-1:0]     m_tuser,  // [0] action, [1] from_version_one
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mld_pkg::BYTE_W-1:0]          cfg_data
);

    logic                         in_valid_reg, in_valid_next;
    logic [mld_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                         in_start_reg;
    logic                         out_valid_reg, out_valid_next;
    mld_pkg::event_t              out_evt_reg;
    mld_pkg::event_t              evt;
    logic [mld_pkg::BYTE_W-1:0]   tag_byte_reg;
    logic [mld_pkg::PORT_W-1:0]   tag_nibble_reg;
    logic                         stall;
    logic                         step;
    logic                         s_fire;

    assign stall     = out_valid_reg && !m_tready;
    assign step      = in_valid_reg && !stall;
    assign s_tready  = !in_valid_reg || !stall;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_fire ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? evt.valid : (m_tready ? 1'b0 : out_valid_reg);

    mld_parser u_parser
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .data_byte        (in_byte_reg),
        .start_of_message (in_start_reg),
        .port_tag_byte    (tag_byte_reg),
        .port_tag_nibble  (tag_nibble_reg),
        .evt              (evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            tag_byte_reg   <= mld_pkg::TAG_BYTE_RESET;
            tag_nibble_reg <= mld_pkg::TAG_NIBBLE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    mld_pkg::CFG_PORT_TAG_BYTE:   tag_byte_reg   <= cfg_data;
                    mld_pkg::CFG_PORT_TAG_NIBBLE: tag_nibble_reg <= cfg_data[3:0];
                    default:                      tag_byte_reg   <= tag_byte_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (step)
        begin
            out_evt_reg <= evt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0,
                       out_evt_reg.source[63:0],
                       out_evt_reg.source[127:64],
                       out_evt_reg.group[63:0],
                       out_evt_reg.group[127:64],
                       out_evt_reg.port};
    assign m_tuser  = {out_evt_reg.from_version_one, out_evt_reg.action};

    a_hold_input_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && stall |-> !s_tready)
        else $error("input taken while parser held");

    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(step))
        else $error("result appeared without a parser step");

    a_v1_no_source: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[259:132] == '0)
        else $error("version one event carries a source");

    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !out_valid_reg || m_tready)
        else $error("parser advanced over a waiting result");

endmodule

/* src/mld_parser.sv */
// Byte-serial MLD message parser: state update and event decode for one byte.
`timescale 1ns / 1ps

module mld_parser
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [mld_pkg::BYTE_W-1:0] data_byte,
    input  logic                       start_of_message,
    input  logic [mld_pkg::BYTE_W-1:0] port_tag_byte,
    input  logic [mld_pkg::PORT_W-1:0] port_tag_nibble,
    output mld_pkg::event_t            evt
);

    mld_pkg::phase_t              phase_reg, phase_next;
    logic [mld_pkg::POS_W-1:0]    pos_reg, pos_next;
    mld_pkg::kind_t               kind_reg, kind_next;
    logic [mld_pkg::PORT_W-1:0]   tagged_port_reg, tagged_port_next;
    logic [mld_pkg::COUNT_W-1:0]  records_left_reg, records_left_next;
    logic [mld_pkg::COUNT_W-1:0]  sources_left_reg, sources_left_next;
    logic [mld_pkg::AUX_W-1:0]    aux_left_reg, aux_left_next;
    logic [mld_pkg::BYTE_W-1:0]   record_type_reg, record_type_next;
    logic [mld_pkg::ADDR_W-1:0]   group_reg, group_next;
    logic [mld_pkg::ADDR_W-1:0]   source_reg, source_next;

    logic [mld_pkg::ADDR_W-1:0]   group_shifted;
    logic [mld_pkg::ADDR_W-1:0]   source_shifted;
    logic [mld_pkg::COUNT_W-1:0]  word16;
    logic [mld_pkg::COUNT_W-1:0]  records_dec;
    logic [mld_pkg::COUNT_W-1:0]  sources_dec;
    logic [mld_pkg::AUX_W-1:0]    aux_dec;
    logic                         rec_known;
    logic                         rec_leave;

    assign group_shifted  = {group_reg[mld_pkg::ADDR_W-9:0], data_byte};
    assign source_shifted = {source_reg[mld_pkg::ADDR_W-9:0], data_byte};
    assign word16         = {source_reg[7:0], data_byte};
    assign records_dec    = records_left_reg - 16'd1;
    assign sources_dec    = sources_left_reg - 16'd1;
    assign aux_dec        = aux_left_reg - 10'd1;

    assign rec_leave = (record_type_reg == mld_pkg::REC_IS_INCLUDE)
                    || (record_type_reg == mld_pkg::REC_TO_INCLUDE);
    assign rec_known = rec_leave
                    || (record_type_reg == mld_pkg::REC_IS_EXCLUDE)
                    || (record_type_reg == mld_pkg::REC_TO_EXCLUDE);

    always_comb
    begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        kind_next         = kind_reg;
        tagged_port_next  = tagged_port_reg;
        records_left_next = records_left_reg;
        sources_left_next = sources_left_reg;
        aux_left_next     = aux_left_reg;
        record_type_next  = record_type_reg;
        group_next        = group_reg;
        source_next       = source_reg;

        evt.valid            = 1'b0;
        evt.action           = rec_leave;
        evt.from_version_one = 1'b0;
        evt.port             = tagged_port_reg;
        evt.group            = group_reg;
        evt.source           = '0;

        if (start_of_message)
        begin
            case (data_byte)
                mld_pkg::TYPE_V1_REPORT: kind_next = mld_pkg::KIND_V1_JOIN;
                mld_pkg::TYPE_V1_DONE:   kind_next = mld_pkg::KIND_V1_LEAVE;
                mld_pkg::TYPE_V2_REPORT: kind_next = mld_pkg::KIND_V2;
                default:                 kind_next = mld_pkg::KIND_NONE;
            endcase
            phase_next        = (kind_next == mld_pkg::KIND_NONE) ? mld_pkg::PH_IDLE
                                                                   : mld_pkg::PH_HEADER;
            pos_next          = 4'd1;
            tagged_port_next  = '0;
            records_left_next = '0;
            sources_left_next = '0;
            aux_left_next     = '0;
            record_type_next  = '0;
        end
        else
        begin
            case (phase_reg)
                mld_pkg::PH_HEADER:
                begin
                    source_next = source_shifted;
                    if (pos_reg == mld_pkg::POS_CSUM_LOW
                        && word16[15:8] == port_tag_byte
                        && word16[7:4] == port_tag_nibble)
                    begin
                        tagged_port_next = word16[3:0];
                    end
                    if (pos_reg == mld_pkg::POS_HDR_LAST)
                    begin
                        pos_next = '0;
                        if (kind_reg == mld_pkg::KIND_V2)
                        begin
                            records_left_next = word16;
                            phase_next = (word16 == '0) ? mld_pkg::PH_IDLE
                                                        : mld_pkg::PH_RECHDR;
                        end
                        else
                        begin
                            phase_next = mld_pkg::PH_GROUP;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                mld_pkg::PH_RECHDR:
                begin
                    pos_next = pos_reg + 4'd1;
                    case (pos_reg)
                        mld_pkg::POS_REC_TYPE:  record_type_next = data_byte;
                        mld_pkg::POS_REC_AUX:   aux_left_next = {data_byte, 2'b00};
                        mld_pkg::POS_REC_NSRCH: sources_left_next = {data_byte, 8'h00};
                        default:
                        begin
                            sources_left_next = {sources_left_reg[15:8], data_byte};
                            phase_next        = mld_pkg::PH_GROUP;
                            pos_next          = '0;
                        end
                    endcase
                end
                mld_pkg::PH_GROUP:
                begin
                    group_next = group_shifted;
                    evt.group  = group_shifted;
                    if (pos_reg == mld_pkg::POS_ADDR_LAST)
                    begin
                        pos_next = '0;
                        if (kind_reg != mld_pkg::KIND_V2)
                        begin
                            evt.valid            = 1'b1;
                            evt.action           = (kind_reg == mld_pkg::KIND_V1_LEAVE);
                            evt.from_version_one = 1'b1;
                            phase_next           = mld_pkg::PH_IDLE;
                        end
                        else if (sources_left_reg == '0)
                        begin
                            evt.valid = rec_known;
                            if (aux_left_reg != '0)
                            begin
                                phase_next = mld_pkg::PH_AUX;
                            end
                            else
                            begin
                                records_left_next = records_dec;
                                phase_next = (records_dec == '0) ? mld_pkg::PH_IDLE
                                                                 : mld_pkg::PH_RECHDR;
                            end
                        end
                        else
                        begin
                            phase_next = mld_pkg::PH_SOURCE;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                mld_pkg::PH_SOURCE:
                begin
                    source_next = source_shifted;
                    if (pos_reg == mld_pkg::POS_ADDR_LAST)
                    begin
                        pos_next          = '0;
                        evt.valid         = rec_known;
                        evt.source        = source_shifted;
                        sources_left_next = sources_dec;
                        if (sources_dec == '0)
                        begin
                            if (aux_left_reg != '0)
                            begin
                                phase_next = mld_pkg::PH_AUX;
                            end
                            else
                            begin
                                records_left_next = records_dec;
                                phase_next = (records_dec == '0) ? mld_pkg::PH_IDLE
                                                                 : mld_pkg::PH_RECHDR;
                            end
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                mld_pkg::PH_AUX:
                begin
                    aux_left_next = aux_dec;
                    if (aux_dec == '0)
                    begin
                        pos_next          = '0;
                        records_left_next = records_dec;
                        phase_next = (records_dec == '0) ? mld_pkg::PH_IDLE
                                                         : mld_pkg::PH_RECHDR;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (!step)
        begin
            evt.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= mld_pkg::PH_IDLE;
            pos_reg          <= '0;
            kind_reg         <= mld_pkg::KIND_NONE;
            tagged_port_reg  <= '0;
            records_left_reg <= '0;
            sources_left_reg <= '0;
            aux_left_reg     <= '0;
            record_type_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            kind_reg         <= kind_next;
            tagged_port_reg  <= tagged_port_next;
            records_left_reg <= records_left_next;
            sources_left_reg <= sources_left_next;
            aux_left_reg     <= aux_left_next;
            record_type_reg  <= record_type_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            group_reg  <= group_next;
            source_reg <= source_next;
        end
    end

endmodule
